/* hdl/tdpt_pkg.sv */
// Shared constants and types for the trial-division prime tester.
`default_nettype none

package tdpt_pkg;

    // Default width of the candidate word.
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // The smallest prime and the first odd divisor tried.
    localparam int FIRST_DIVISOR = 2;
    localparam int FIRST_ODD_DIVISOR = 3;

    // Sequencer states, one-hot coded.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_CHECK  = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

endpackage

`default_nettype wire

/* hdl/trial_division_prime_test.sv */
// Trial-division prime tester built around one bit-serial restoring divider.
// Each odd trial divisor, from three upward, takes one full division in the divider, which
// retires one quotient bit per cycle; even numbers and numbers below two skip the divider.
// One word is in work at a time; a finished result waits in the output register while
// the next word is accepted.
// Reset (rst_n, asynchronous, active low) clears the sequencer and the output valid flag.
`default_nettype none

module trial_division_prime_test #(
    parameter int VALUE_WIDTH = tdpt_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [VALUE_WIDTH-1:0] candidate,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [VALUE_WIDTH-1:0]      tested_value,
    output logic                        is_prime
);

    localparam int CW = $clog2(VALUE_WIDTH);
    localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_WIDTH - 1);
    localparam logic [VALUE_WIDTH-1:0] TWO = VALUE_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
    localparam logic [VALUE_WIDTH-1:0] THREE = VALUE_WIDTH'(tdpt_pkg::FIRST_ODD_DIVISOR);

    tdpt_pkg::state_t state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;
    logic                   verdict_reg, verdict_next;
    logic [VALUE_WIDTH-1:0] tested_value_reg, tested_value_next;
    logic                   is_prime_reg, is_prime_next;

    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH+1:0] trial;
    logic                   fits;
    logic                   out_free;

    // One restoring division step: bring down the next dividend bit and subtract if it fits.
    assign rem_shift = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, div_reg};
    assign fits      = ~trial[VALUE_WIDTH+1];

    assign out_free  = ~out_valid_reg | out_ready;
    assign in_ready  = (state_reg == tdpt_pkg::ST_IDLE);

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        n_next            = n_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        div_next          = div_reg;
        verdict_next      = verdict_reg;
        tested_value_next = tested_value_reg;
        is_prime_next     = is_prime_reg;
        out_valid_next    = out_valid_reg & ~out_ready;

        unique case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next = candidate;
                    if (candidate[VALUE_WIDTH-1:1] == '0)
                    begin
                        // Zero and one are not prime.
                        verdict_next = 1'b0;
                        state_next   = tdpt_pkg::ST_REPORT;
                    end
                    else if (!candidate[0])
                    begin
                        // An even number is prime only when it is two.
                        verdict_next = (candidate == TWO);
                        state_next   = tdpt_pkg::ST_REPORT;
                    end
                    else
                    begin
                        div_next   = THREE;
                        quo_next   = candidate;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = tdpt_pkg::ST_DIVIDE;
                    end
                end
            end

            tdpt_pkg::ST_DIVIDE:
            begin
                quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
                rem_next = fits ? trial[VALUE_WIDTH-1:0] : rem_shift[VALUE_WIDTH-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_BIT)
                begin
                    state_next = tdpt_pkg::ST_CHECK;
                end
            end

            tdpt_pkg::ST_CHECK:
            begin
                if (div_reg > quo_reg)
                begin
                    // Divisor passed the square root: no factor exists.
                    verdict_next = 1'b1;
                    state_next   = tdpt_pkg::ST_REPORT;
                end
                else if (rem_reg == '0)
                begin
                    verdict_next = 1'b0;
                    state_next   = tdpt_pkg::ST_REPORT;
                end
                else
                begin
                    div_next   = div_reg + TWO;
                    quo_next   = n_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = tdpt_pkg::ST_DIVIDE;
                end
            end

            tdpt_pkg::ST_REPORT:
            begin
                if (out_free)
                begin
                    tested_value_next = n_reg;
                    is_prime_next     = verdict_reg;
                    out_valid_next    = 1'b1;
                    state_next        = tdpt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdpt_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output word registers.
    always_ff @(posedge clk)
    begin
        n_reg            <= n_next;
        quo_reg          <= quo_next;
        rem_reg          <= rem_next;
        div_reg          <= div_next;
        verdict_reg      <= verdict_next;
        tested_value_reg <= tested_value_next;
        is_prime_reg     <= is_prime_next;
    end

    assign out_valid    = out_valid_reg;
    assign tested_value = tested_value_reg;
    assign is_prime     = is_prime_reg;

endmodule

`default_nettype wire

/* tb/prime_result_checker.sv */
// Checker for the prime tester: predicts each verdict word and compares it with the block's output.

module prime_result_checker #(
    parameter int W = tdpt_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic [W-1:0] candidate,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [W-1:0] tested_value,
    input  logic         is_prime,
    output int           outstanding,
    output int           fail_count
);

    typedef struct packed {
        logic [W-1:0] value;
        logic         prime;
    } verdict_t;

    // Verdicts still owed by the block, oldest first.
    verdict_t owed_verdicts[$];
    int       mismatches = 0;

    // Trial division over odd divisors; the bound is kept as d <= n / d so it
    // never overflows.
    function automatic logic trial_prime(input logic [W-1:0] word);
        longint unsigned n;
        longint unsigned d;
        n = longint'(word);
        if (n < tdpt_pkg::FIRST_DIVISOR)
            return 1'b0;
        if (n % tdpt_pkg::FIRST_DIVISOR == 0)
            return n == tdpt_pkg::FIRST_DIVISOR;
        for (d = tdpt_pkg::FIRST_ODD_DIVISOR; d <= n / d; d += 2)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Retire the output word first, since a word accepted at this edge cannot
    // already have its verdict on the output.
    always @(posedge clk)
    begin : watch_channels
        verdict_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (owed_verdicts.size() == 0)
                begin
                    $error("unexpected result word: tested_value=%0d is_prime=%0b",
                           tested_value, is_prime);
                    mismatches++;
                end
                else
                begin
                    want = owed_verdicts.pop_front();
                    if (tested_value !== want.value)
                    begin
                        $error("tested_value: expected %0d, got %0d", want.value, tested_value);
                        mismatches++;
                    end
                    if (is_prime !== want.prime)
                    begin
                        $error("is_prime for %0d: expected %0b, got %0b",
                               want.value, want.prime, is_prime);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                owed_verdicts.push_back(verdict_t'{value: candidate,
                                                   prime: trial_prime(candidate)});
        end
        outstanding <= owed_verdicts.size();
        fail_count  <= mismatches;
    end

endmodule

/* tb/trial_division_prime_test_tb.sv */
// Top of the prime tester testbench: clock, reset, word stimulus, output stalls and verdict.

module trial_division_prime_test_tb;

    localparam int W            = tdpt_pkg::DEFAULT_VALUE_WIDTH;
    localparam int CYCLE_LIMIT  = 16_000_000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_WORDS = 100;
    localparam int MAX_GAP      = 18;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         in_valid  = 1'b0;
    logic [W-1:0] candidate = '0;
    logic         out_ready = 1'b0;
    wire          in_ready;
    wire          out_valid;
    wire  [W-1:0] tested_value;
    wire          is_prime;
    int           outstanding;
    int           fail_count;
    int unsigned  cycle_count = 0;
    int           send_burst  = 0;
    int           take_burst  = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    trial_division_prime_test #(
        .VALUE_WIDTH (W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .candidate    (candidate),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tested_value (tested_value),
        .is_prime     (is_prime)
    );

    prime_result_checker #(
        .W (W)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .candidate    (candidate),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tested_value (tested_value),
        .is_prime     (is_prime),
        .outstanding  (outstanding),
        .fail_count   (fail_count)
    );

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("trial_division_prime_test_tb: errors");
            $finish;
        end
    end

    // Idle cycles before the next word; now and then a burst runs with no gaps.
    function automatic int draw_gap(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 4) == 0)
        begin
            burst = $urandom_range(5, 15);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Most candidates stay small so that the divider loop stays short; full-width
    // words are made to carry a small factor so they finish early.
    function automatic logic [W-1:0] random_candidate();
        logic [W-1:0] raw;
        int unsigned  factor;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return W'($urandom_range(0, 65535));
            4, 5:       return W'($urandom_range(0, 1 << 20));
            6:          return W'($urandom_range(0, 1 << 22) | 1);
            7:          return raw & ~W'(1);
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       factor = 3;
                    1:       factor = 5;
                    2:       factor = 7;
                    3:       factor = 11;
                    default: factor = 13;
                endcase
                return W'((raw / factor) * factor);
            end
        endcase
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [W-1:0] value);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= value;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    // Stop offering words until every verdict has come back.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Result side: random stalls before each word is taken.
    initial
    begin : take_results
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = draw_gap(take_burst);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // Reset, directed words, random words, then the verdict.
    initial
    begin : stimulus
        logic [W-1:0] directed_words[$];
        directed_words = '{
            0, 1, 2, 3, 4, 5, 9, 25, 49,          // edges around the first divisors
            65521, 65537, 1022117, 16777213,      // primes and a near-square semiprime
            32'hFFFF_FFFF, 32'hFFFF_FFFE,         // top of the range
            32'h8000_0000, 32'hAAAA_AAAA,
            32'h5555_5555, 32'd4294836225         // square of an odd composite
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_words[k])
            send_word(directed_words[k]);
        hold_until_drained();
        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            if (k == RANDOM_WORDS / 2)
                hold_until_drained();
            send_word(random_candidate());
        end
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("trial_division_prime_test_tb: clean");
        else
            $display("trial_division_prime_test_tb: errors");
        $finish;
    end

endmodule

/* sim.f */
hdl/tdpt_pkg.sv
hdl/trial_division_prime_test.sv
tb/prime_result_checker.sv
tb/trial_division_prime_test_tb.sv
